[hw/rtl/url_percent_decoder_defines.svh]
// ----------------------------------------------------------------------------
// url_percent_decoder_defines.svh
// Assertion macros used by the checker file of the URL decoder.
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define UPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/upd_pkg.sv]
// ----------------------------------------------------------------------------
// upd_pkg
// Types, constants and helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam int unsigned CharW      = 8;
  localparam int unsigned LenW       = 11;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned FifoDepth  = 4;

  localparam logic [CharW-1:0] ChPlus    = 8'h2B;
  localparam logic [CharW-1:0] ChPercent = 8'h25;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChZero    = 8'h30;
  localparam logic [CharW-1:0] ChNine    = 8'h39;
  localparam logic [CharW-1:0] ChLowA    = 8'h61;
  localparam logic [CharW-1:0] ChLowF    = 8'h66;
  localparam logic [CharW-1:0] ChUpA     = 8'h41;
  localparam logic [CharW-1:0] ChUpF     = 8'h46;

  localparam logic [LenW-1:0] LimitReset = 11'd1024;

  typedef enum logic [1:0] {
    PhNormal  = 2'd0,
    PhPercent = 2'd1,
    PhDigit   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             is_data;
    logic             eos;
    logic [LenW-1:0]  len;
  } result_t;

  // All results of one input byte; only res[0..n-1] are meaningful.
  typedef struct packed {
    logic [1:0]                 n;
    result_t [MaxResults-1:0]   res;
  } bundle_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(logic [CharW-1:0] c);
    hex_t             h;
    logic [CharW-1:0] diff;
    h    = '0;
    diff = '0;
    if (c >= ChZero && c <= ChNine) begin
      diff    = c - ChZero;
      h.valid = 1'b1;
      h.nib   = diff[3:0];
    end else if (c >= ChLowA && c <= ChLowF) begin
      diff    = c - ChLowA + 8'd10;
      h.valid = 1'b1;
      h.nib   = diff[3:0];
    end else if (c >= ChUpA && c <= ChUpF) begin
      diff    = c - ChUpA + 8'd10;
      h.valid = 1'b1;
      h.nib   = diff[3:0];
    end
    return h;
  endfunction

endpackage

[hw/rtl/upd_decode.sv]
// ----------------------------------------------------------------------------
// upd_decode
// Escape state machine and emit counter; combinationally turns one registered
// byte into a bundle of up to three results.
// ----------------------------------------------------------------------------
module upd_decode
  import upd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [CharW-1:0] char_i,
  input  logic             last_i,
  input  logic [LenW-1:0]  limit_i,
  output bundle_t          bundle_o
);

  phase_e           phase_q, phase_d;
  logic [CharW-1:0] held_q, held_d;
  logic [LenW-1:0]  cnt_q, cnt_d;

  hex_t             hx, hh;
  logic             lim_ok, need_a, need_b, use_plain, plain_ok;
  logic [CharW-1:0] a_char, b_char;
  logic [LenW-1:0]  cnt1, cnt2;
  result_t          e_a, e_b, e_end;

  always_comb begin
    hx     = hex_decode(char_i);
    hh     = hex_decode(held_q);
    lim_ok = cnt_q < limit_i;
    need_a = lim_ok && (phase_q == PhDigit);
    a_char = hx.valid ? {hh.nib, hx.nib} : held_q;
    case (phase_q)
      PhPercent: use_plain = lim_ok && !(hx.valid && !last_i);
      PhDigit:   use_plain = lim_ok && !hx.valid;
      default:   use_plain = lim_ok;
    endcase
    cnt1     = cnt_q + {{(LenW-1){1'b0}}, need_a};
    plain_ok = use_plain && (cnt1 < limit_i);
    need_b   = plain_ok && (char_i != ChPercent);
    b_char   = (char_i == ChPlus) ? ChSpace : char_i;
    cnt2     = cnt1 + {{(LenW-1){1'b0}}, need_b};
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    cnt_d   = cnt_q;
    if (lim_ok) begin
      phase_d = PhNormal;
      cnt_d   = cnt2;
      if (phase_q == PhPercent && hx.valid && !last_i) begin
        phase_d = PhDigit;
        held_d  = char_i;
      end
      if (phase_q == PhDigit) held_d = '0;
      // a '%' on the last byte is simply dropped
      if (plain_ok && char_i == ChPercent && !last_i) phase_d = PhPercent;
    end
    if (last_i) begin
      phase_d = PhNormal;
      held_d  = '0;
      cnt_d   = '0;
    end
  end

  // Result bundle
  always_comb begin
    e_a   = '{ch: a_char, is_data: 1'b1, eos: 1'b0, len: cnt1};
    e_b   = '{ch: b_char, is_data: 1'b1, eos: 1'b0, len: cnt2};
    e_end = '{ch: '0, is_data: 1'b0, eos: 1'b1, len: cnt2};
    bundle_o.res[0] = need_a ? e_a : (need_b ? e_b : e_end);
    bundle_o.res[1] = (need_a && need_b) ? e_b : e_end;
    bundle_o.res[2] = e_end;
    bundle_o.n      = {1'b0, need_a} + {1'b0, need_b} + {1'b0, last_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhNormal;
      held_q  <= '0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[hw/rtl/upd_res_fifo.sv]
// ----------------------------------------------------------------------------
// upd_res_fifo
// Queue of result bundles; the head bundle is sent out one beat at a time.
// ----------------------------------------------------------------------------
module upd_res_fifo
  import upd_pkg::*;
#(
  parameter int unsigned Depth = FifoDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      sub_q;

  bundle_t head;
  logic    beat, last_beat, pop;

  assign head        = mem_q[rd_ptr_q];
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = head.res[sub_q];
  assign full_o      = (cnt_q == CntW'(Depth));
  assign beat        = out_valid_o && out_ready_i;
  assign last_beat   = (sub_q == 2'(head.n - 2'd1));
  assign pop         = beat && last_beat;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) cnt_d = cnt_q + CntW'(1);
    if (!push_i && pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      sub_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
        sub_q    <= '0;
      end else if (beat) begin
        sub_q <= sub_q + 2'd1;
      end
    end
  end

endmodule

[hw/rtl/url_percent_decoder.sv]
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent decoder: '+' to space, %XX to one byte, byte count
// limit per string, end record with the decoded length after the last byte.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_axis    in   tdata[7:0] in_char, tlast is_final
//  m_axis    out  tdata[7:0] out_char, [18:8] decoded_length; tuser is_data;
//                 tlast end_of_string
//  cfg       in   cfg_wdata_i output_limit, written when cfg_we_i is high
//
//  One byte accepted per cycle; a byte passes the input register, then the
//  queue. It yields 0 to 3 results, one beat per cycle while m_axis_tready
//  is high, from a queue of FifoDepth bundles; input stalls only while full.
//  Reset: escape state and count cleared, output_limit = 1024; no clear pass.
// ----------------------------------------------------------------------------
module url_percent_decoder
  import upd_pkg::*;
#(
  parameter int unsigned FifoDepthP = FifoDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] in_char
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // [7:0] out_char, [18:8] decoded_length
  output logic                  m_axis_tuser,   // [0] is_data
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [LenW-1:0]       cfg_wdata_i
);

  logic             in_vld_q, in_vld_d;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;
  logic [LenW-1:0]  limit_q;

  logic    load, fire, full, push;
  bundle_t bundle;
  result_t res;

  assign fire          = in_vld_q && !full;
  assign s_axis_tready = !in_vld_q || fire;
  assign load          = s_axis_tvalid && s_axis_tready;
  assign push          = fire && (bundle.n != 2'd0);

  always_comb begin
    in_vld_d = in_vld_q;
    if (fire) in_vld_d = 1'b0;
    if (load) in_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      limit_q  <= LimitReset;
    end else begin
      in_vld_q <= in_vld_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  upd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .char_i   (in_char_q),
    .last_i   (in_last_q),
    .limit_i  (limit_q),
    .bundle_o (bundle)
  );

  upd_res_fifo #(
    .Depth (FifoDepthP)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (bundle),
    .full_o      (full),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {5'b0, res.len, res.ch};
  assign m_axis_tuser = res.is_data;
  assign m_axis_tlast = res.eos;

endmodule

[hw/rtl/upd_checker.sv]
// ----------------------------------------------------------------------------
// upd_checker
// Port-level checks on the result stream of the URL decoder.
// ----------------------------------------------------------------------------
`include "url_percent_decoder_defines.svh"

module upd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // every beat is either a data byte or the end record, never both
  `UPD_ASSERT_IMPL(a_kind_excl, m_axis_tvalid, m_axis_tuser != m_axis_tlast, "beat kind bad")

  `UPD_ASSERT_IMPL(a_end_char_zero, m_axis_tvalid && m_axis_tlast,
    m_axis_tdata[7:0] == 8'h00, "end record carries a byte")

  // a data beat counts itself, so its length is never zero
  `UPD_ASSERT_IMPL(a_data_len, m_axis_tvalid && m_axis_tuser,
    m_axis_tdata[18:8] != 11'd0, "data beat with zero length")

  `UPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled beat changed")

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
